// ----- hw/rtl/bgcs_pkg.sv -----
package bgcs_pkg;

  // Grid limits and derived widths
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int CFG_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
  localparam int COORD_W     = 13;
  localparam int RESET_DIM   = 1024;

  // Bus widths
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 4 * COORD_W;

  // Register indexes, taken from the upper address bit
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef logic [COL_W-1:0]          col_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [CFG_W-1:0]          cfg_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Edge midpoints of one cell
  typedef enum logic [1:0] {
    PT_TOP    = 2'd0,
    PT_RIGHT  = 2'd1,
    PT_BOTTOM = 2'd2,
    PT_LEFT   = 2'd3
  } pt_e;

  typedef struct packed {
    logic [1:0] count;
    pt_e        s0;
    pt_e        e0;
    pt_e        s1;
    pt_e        e1;
  } case_t;

  // One closed 2x2 cell
  typedef struct packed {
    col_t col;
    row_t row;
    logic tl;
    logic tr;
    logic br;
    logic bl;
  } cell_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } seg_t;

  typedef struct packed {
    logic [1:0] count;
    seg_t       seg;
  } dec_t;

  // Segment table, solid on the left of each segment
  function automatic case_t case_lookup(logic [3:0] idx);
    case_t ct;
    ct = '{count: 2'd0, s0: PT_TOP, e0: PT_TOP, s1: PT_TOP, e1: PT_TOP};
    unique case (idx)
      4'd0:  ct.count = 2'd0;
      4'd1:  ct = '{2'd1, PT_LEFT,   PT_TOP,    PT_TOP,    PT_TOP};
      4'd2:  ct = '{2'd1, PT_TOP,    PT_RIGHT,  PT_TOP,    PT_TOP};
      4'd3:  ct = '{2'd1, PT_LEFT,   PT_RIGHT,  PT_TOP,    PT_TOP};
      4'd4:  ct = '{2'd1, PT_RIGHT,  PT_BOTTOM, PT_TOP,    PT_TOP};
      4'd5:  ct = '{2'd2, PT_LEFT,   PT_TOP,    PT_RIGHT,  PT_BOTTOM};
      4'd6:  ct = '{2'd1, PT_TOP,    PT_BOTTOM, PT_TOP,    PT_TOP};
      4'd7:  ct = '{2'd1, PT_LEFT,   PT_BOTTOM, PT_TOP,    PT_TOP};
      4'd8:  ct = '{2'd1, PT_BOTTOM, PT_LEFT,   PT_TOP,    PT_TOP};
      4'd9:  ct = '{2'd1, PT_BOTTOM, PT_TOP,    PT_TOP,    PT_TOP};
      4'd10: ct = '{2'd2, PT_TOP,    PT_RIGHT,  PT_BOTTOM, PT_LEFT};
      4'd11: ct = '{2'd1, PT_BOTTOM, PT_RIGHT,  PT_TOP,    PT_TOP};
      4'd12: ct = '{2'd1, PT_RIGHT,  PT_LEFT,   PT_TOP,    PT_TOP};
      4'd13: ct = '{2'd1, PT_RIGHT,  PT_TOP,    PT_TOP,    PT_TOP};
      4'd14: ct = '{2'd1, PT_TOP,    PT_LEFT,   PT_TOP,    PT_TOP};
      default: ct.count = 2'd0;
    endcase
    return ct;
  endfunction

  // Map a register value to the usable column range
  function automatic col_t clamp_w(cfg_t v);
    col_t res;
    if (v == '0) begin
      res = col_t'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = col_t'(MAX_WIDTH);
    end else begin
      res = col_t'(v);
    end
    return res;
  endfunction

  function automatic row_t clamp_h(cfg_t v);
    row_t res;
    if (v == '0) begin
      res = row_t'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      res = row_t'(MAX_HEIGHT);
    end else begin
      res = row_t'(v);
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/binary_grid_contour_segments_unit.sv -----
// Channel   | Direction | Carries
// s_axis    | in        | tdata[0] pixel_solid, one request per grid position, padding column and row included
// m_axis    | out       | tdata start_x2/start_y2/end_x2/end_y2, tlast last_of_cell
// APB       | in/out    | grid_width at 0x0, grid_height at 0x4
//
// One pixel is taken per cycle while the cell stage can retire; a cell passes from
// the cell stage register to the output register, the row store read being registered with the cell stage.
// Saddle cells hold the cell stage until both segments, one per output, have moved out.
// Reset clears counters, edge bits and valid flags; the row store needs no
// clearing since each row reads only entries the previous row wrote.
// Back-pressure on m_axis stalls the cell stage and then s_axis.
module binary_grid_contour_segments_unit import bgcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Pixel stream: [0] pixel_solid
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Segment stream: [12:0] start_x2, [25:13] start_y2, [38:26] end_x2, [51:39] end_y2
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t  width_cfg_q, height_cfg_q;
  col_t  w;
  row_t  h;
  logic  cfg_wr;

  col_t  col_q, col_d;
  row_t  row_q, row_d;
  logic  in_acc;
  logic  br_in;

  logic  prev_row_mem [MAX_WIDTH+1];
  logic  prev_rd_q;

  logic  s1_valid_q;
  col_t  s1_col_q;
  row_t  s1_row_q;
  logic  s1_br_q;
  logic  left_upper_q, left_lower_q;
  logic  seg_sel_q;

  cell_t cur_cell;
  dec_t  dec;
  logic  out_free, emit, retire;

  logic  out_valid_q;
  seg_t  out_seg_q;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[ADDR_W-1] == REG_GRID_HEIGHT) ? DATA_W'(height_cfg_q)
                                                       : DATA_W'(width_cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= cfg_t'(RESET_DIM);
      height_cfg_q <= cfg_t'(RESET_DIM);
    end else if (cfg_wr) begin
      if (paddr[ADDR_W-1] == REG_GRID_WIDTH) begin
        width_cfg_q <= pwdata[CFG_W-1:0];
      end else begin
        height_cfg_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign w = clamp_w(width_cfg_q);
  assign h = clamp_h(height_cfg_q);

  // Raster position of the next request; wrap at the padding column and row
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign br_in  = s_axis_tdata[0] & (col_q < w) & (row_q < h);

  always_comb begin
    if (col_q >= w) begin
      col_d = '0;
      row_d = (row_q >= h) ? '0 : row_q + row_t'(1);
    end else begin
      col_d = col_q + col_t'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Row store: read the pixel above, then overwrite it with this one
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_rd_q           <= prev_row_mem[col_q];
      prev_row_mem[col_q] <= br_in;
    end
  end

  // Cell stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_br_q  <= br_in;
    end
  end

  // Assemble the cell; the implicit top row and left column read as empty
  always_comb begin
    cur_cell.col = s1_col_q;
    cur_cell.row = s1_row_q;
    cur_cell.tr  = (s1_row_q == '0) ? 1'b0 : prev_rd_q;
    cur_cell.br  = s1_br_q;
    cur_cell.tl  = (s1_col_q == '0) ? 1'b0 : left_upper_q;
    cur_cell.bl  = (s1_col_q == '0) ? 1'b0 : left_lower_q;
  end

  bgcs_seg_decode u_seg_decode (
    .cell_i    (cur_cell),
    .seg_sel_i (seg_sel_q),
    .dec_o     (dec)
  );

  // Advance the cell stage once its last segment moves to the output, or at once if it has none
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign emit          = s1_valid_q & (dec.count != 2'd0) & out_free;
  assign retire        = s1_valid_q & ((dec.count == 2'd0) | (out_free & dec.seg.last));
  assign s_axis_tready = ~s1_valid_q | retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      seg_sel_q    <= 1'b0;
      left_upper_q <= 1'b0;
      left_lower_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire) begin
        seg_sel_q    <= 1'b0;
        left_upper_q <= cur_cell.tr;
        left_lower_q <= cur_cell.br;
      end else if (emit) begin
        seg_sel_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_seg_q <= dec.seg;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_seg_q.last;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_seg_q.ey, out_seg_q.ex,
                          out_seg_q.sy, out_seg_q.sx};

endmodule

// ----- hw/rtl/bgcs_seg_decode.sv -----
module bgcs_seg_decode import bgcs_pkg::*; (
  input  cell_t cell_i,
  input  logic  seg_sel_i,
  output dec_t  dec_o
);

  case_t  ct;
  pt_e    sp;
  pt_e    ep;
  coord_t x_base;
  coord_t y_base;

  // Doubled cell position, extended to the coordinate width
  assign x_base = coord_t'({cell_i.col, 1'b0});
  assign y_base = coord_t'({cell_i.row, 1'b0});

  assign ct = case_lookup({cell_i.bl, cell_i.br, cell_i.tr, cell_i.tl});
  assign sp = seg_sel_i ? ct.s1 : ct.s0;
  assign ep = seg_sel_i ? ct.e1 : ct.e0;

  // Place start and end on the cell's edge midpoints
  always_comb begin
    dec_o.count    = ct.count;
    dec_o.seg.last = (ct.count == 2'd2) ? seg_sel_i : 1'b1;
    case (sp)
      PT_TOP:    begin dec_o.seg.sx = x_base;             dec_o.seg.sy = y_base - coord_t'(1); end
      PT_RIGHT:  begin dec_o.seg.sx = x_base + coord_t'(1); dec_o.seg.sy = y_base;             end
      PT_BOTTOM: begin dec_o.seg.sx = x_base;             dec_o.seg.sy = y_base + coord_t'(1); end
      default:   begin dec_o.seg.sx = x_base - coord_t'(1); dec_o.seg.sy = y_base;             end
    endcase
    case (ep)
      PT_TOP:    begin dec_o.seg.ex = x_base;             dec_o.seg.ey = y_base - coord_t'(1); end
      PT_RIGHT:  begin dec_o.seg.ex = x_base + coord_t'(1); dec_o.seg.ey = y_base;             end
      PT_BOTTOM: begin dec_o.seg.ex = x_base;             dec_o.seg.ey = y_base + coord_t'(1); end
      default:   begin dec_o.seg.ex = x_base - coord_t'(1); dec_o.seg.ey = y_base;             end
    endcase
  end

endmodule

// ----- hw/rtl/bgcs_checker.sv -----
module bgcs_checker import bgcs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // Hold a stalled request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("segment request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("segment payload changed while stalled");

  // Every endpoint is an edge midpoint: exactly one doubled coordinate is odd
  a_mid_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ^ m_axis_tdata[COORD_W])
                   && (m_axis_tdata[2*COORD_W] ^ m_axis_tdata[3*COORD_W]))
    else $error("segment endpoint not on an edge midpoint");

  // The second segment of a saddle follows right behind the first
  a_saddle_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("saddle cell missing its second segment");

endmodule

bind binary_grid_contour_segments_unit bgcs_checker u_bgcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
